### rtl/itsa_pkg.sv
// Package for the sail angle interpolation table.
// Holds request codes, result status codes, the no-position command, divider constants and the result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itsa_pkg;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_FLAG   = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_EXACT  = 2'd0,
    ST_INTERP = 2'd1,
    ST_NONE   = 2'd2,
    ST_ECHO   = 2'd3
  } status_e;

  // Command value that means no position (-1.0 degree in Q9.6).
  localparam logic signed [15:0] NO_POSITION = -16'sd64;

  // The divider takes one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = 5;

  // One result item as it leaves the block.
  typedef struct packed {
    logic        valid;
    logic [15:0] sail_command;
    status_e     status;
    logic        last_of_run;
  } result_t;

endpackage

`default_nettype wire

### rtl/itsa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module itsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/itsa_div.sv
// Restoring unsigned divider, one quotient bit per cycle (32 by 16 bits).
// Depends on itsa_pkg for the step count.
`timescale 1ns / 1ps
`default_nettype none

module itsa_div
  import itsa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [31:0]          dvd_q, dvd_d;
  logic [15:0]          rem_q, rem_d;
  logic [15:0]          dsr_q;
  logic [16:0]          shifted;
  logic [16:0]          rem_n;
  logic                 ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, dvd_q[31]};
    ge      = shifted >= {1'b0, dsr_q};
    rem_n   = ge ? (shifted - {1'b0, dsr_q}) : shifted;
    rem_d   = rem_n[15:0];
    dvd_d   = {dvd_q[30:0], ge};
  end

  // Step sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
        dvd_q <= dividend_i;
        rem_q <= '0;
        dsr_q <= divisor_i;
      end else if (run_q) begin
        dvd_q <= dvd_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

### rtl/interp_table_sail_angle.sv
// Sail angle lookup with piecewise-linear interpolation over an appended table.
// Append and flag items complete in the idle state; busy stays low and the next item may follow.
// A query scans the table once at one entry per cycle (memory read port) and, if it
// finds a bracket but no exact match, multiplies and runs a 32-step divider.
// Results appear on valid_o from a register and cannot be stalled.
// Reset clears the entry count and the reached flag; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module interp_table_sail_angle
  import itsa_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [15:0] wind_angle_i,
  input  wire logic [15:0] entry_angle_i,
  input  wire logic [15:0] entry_position_i,
  input  wire logic        reached_i,
  output logic             valid_o,
  output logic [15:0]      sail_command_o,
  output logic [1:0]       status_o,
  output logic             last_of_run_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DGO,
    S_DIV,
    S_TAIL
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      cnt_q;
  logic               flag_q;
  logic [CW-1:0]      rd_idx_q;
  logic               dv_q;
  logic               have_prev_q;
  logic               brk_q;
  logic signed [15:0] q_q;
  logic signed [15:0] prev_w_q, prev_s_q;
  logic signed [15:0] lw_q, lp_q, uw_q, up_q;
  logic signed [33:0] prod_q;
  logic [15:0]        den_q;
  result_t            res_q, res_d;

  logic               accept;
  logic               full;
  logic               ram_we;
  logic               ram_re;
  logic               issue;
  logic [31:0]        ram_wdata;
  logic [31:0]        ram_rdata;
  logic signed [15:0] rd_w, rd_s;
  logic signed [16:0] dq, ds;
  logic [16:0]        den_w;
  logic signed [33:0] prod_mag;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quot;
  logic signed [17:0] quot_s;
  logic signed [17:0] sum;
  logic signed [15:0] sat;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign full      = (cnt_q == CW'(TABLE_DEPTH));
  assign ram_we    = accept && (req_type_i == REQ_APPEND) && !full;
  assign ram_wdata = {entry_angle_i, entry_position_i};
  assign issue     = (rd_idx_q < cnt_q);
  assign ram_re    = (state_q == S_SCAN) && issue;
  assign rd_w      = ram_rdata[31:16];
  assign rd_s      = ram_rdata[15:0];

  // Table storage: wind angle in the upper half, sail position in the lower.
  itsa_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Interpolation operands; the bracket guarantees a positive distance.
  always_comb begin
    dq       = 17'(q_q) - 17'(lw_q);
    ds       = 17'(up_q) - 17'(lp_q);
    den_w    = 17'(uw_q) - 17'(lw_q);
    prod_mag = prod_q[33] ? -prod_q : prod_q;
  end

  assign div_start = (state_q == S_DGO);

  itsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_mag[31:0]),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Quotient magnitude stays below 2^16; restore the sign and saturate the sum.
  always_comb begin
    quot_s = prod_q[33] ? -$signed({2'b00, div_quot[15:0]})
                        : $signed({2'b00, div_quot[15:0]});
    sum    = 18'(lp_q) + quot_s;
    if (sum > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  // Result of the current cycle; it is valid only where an item finishes or a flagged query echoes.
  always_comb begin
    res_d = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_type_i == REQ_QUERY)) begin
          if (flag_q) begin
            res_d = '{1'b1, wind_angle_i, ST_ECHO, 1'b0};
          end else if (cnt_q == '0) begin
            res_d = '{1'b1, NO_POSITION, ST_NONE, 1'b1};
          end
        end
      end
      S_SCAN: begin
        if (dv_q && (rd_w == q_q)) begin
          res_d = '{1'b1, rd_s, ST_EXACT, 1'b1};
        end else if (!dv_q && !issue && !brk_q) begin
          res_d = '{1'b1, NO_POSITION, ST_NONE, 1'b1};
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d = '{1'b1, sat, ST_INTERP, 1'b1};
        end
      end
      S_TAIL: begin
        res_d = '{1'b1, NO_POSITION, ST_NONE, 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Control sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      rd_idx_q    <= '0;
      dv_q        <= 1'b0;
      have_prev_q <= 1'b0;
      brk_q       <= 1'b0;
      q_q         <= '0;
      prev_w_q    <= '0;
      prev_s_q    <= '0;
      lw_q        <= '0;
      lp_q        <= '0;
      uw_q        <= '0;
      up_q        <= '0;
      prod_q      <= '0;
      den_q       <= '0;
      res_q       <= '0;
    end else begin
      res_q <= res_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_type_i)
              REQ_APPEND: begin
                if (!full) begin
                  cnt_q <= cnt_q + CW'(1);
                end
              end
              REQ_FLAG: begin
                flag_q <= reached_i;
              end
              REQ_QUERY: begin
                q_q <= wind_angle_i;
                if (flag_q) begin
                  state_q <= S_TAIL;
                end else if (cnt_q != '0) begin
                  rd_idx_q    <= '0;
                  dv_q        <= 1'b0;
                  have_prev_q <= 1'b0;
                  brk_q       <= 1'b0;
                  state_q     <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue the next read while checking the entry that just arrived.
          dv_q <= issue;
          if (issue) begin
            rd_idx_q <= rd_idx_q + CW'(1);
          end
          if (dv_q) begin
            if (rd_w == q_q) begin
              state_q <= S_IDLE;
            end else begin
              if (have_prev_q && !brk_q && (prev_w_q < q_q) && (rd_w > q_q)) begin
                brk_q <= 1'b1;
                lw_q  <= prev_w_q;
                lp_q  <= prev_s_q;
                uw_q  <= rd_w;
                up_q  <= rd_s;
              end
              prev_w_q    <= rd_w;
              prev_s_q    <= rd_s;
              have_prev_q <= 1'b1;
            end
          end else if (!issue) begin
            // Scan finished without an exact match.
            if (brk_q) begin
              state_q <= S_MUL;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          prod_q  <= dq * ds;
          den_q   <= den_w[15:0];
          state_q <= S_DGO;
        end
        S_DGO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_IDLE;
          end
        end
        S_TAIL: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign valid_o        = res_q.valid;
  assign sail_command_o = res_q.sail_command;
  assign status_o       = res_q.status;
  assign last_of_run_o  = res_q.last_of_run;

  // An echo result is never the last one and is always followed by no-position.
  a_echo_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == ST_ECHO) |-> !last_of_run_o)
    else $error("echo result marked as last");

  a_echo_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == ST_ECHO) |=> valid_o && (status_o == ST_NONE) && last_of_run_o)
    else $error("echo result not followed by no-position result");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_interp_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == ST_INTERP) |-> $past(div_done))
    else $error("interpolated result without a divider result");

endmodule

`default_nettype wire
